@@ rtl/core/lbvs_pkg.sv @@
// Shared types, constants and command codes for the skinning block.
`timescale 1ns / 1ps
package lbvs_pkg;

  localparam int MAX_JOINTS_DEF = 64;
  localparam int INFLUENCES_DEF = 4;
  localparam int FIELD_INFL     = 4;   // influences carried by the input fields
  localparam int ELEMS          = 12;  // 3x4 affine matrix, row major

  // squared length threshold for a degenerate normal
  localparam logic [63:0] NRM_EPS_SQ = 64'd1237940039285380;
  localparam logic [61:0] RED_LIM    = 62'd1073741824;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_LOAD_ITEM,
    OP_WSUM,
    OP_READ,
    OP_PASS,
    OP_DIV_P_INIT,
    OP_DIV_STEP,
    OP_DIV_P_END,
    OP_SHIFT,
    OP_SQ,
    OP_NRM_BIND,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_N_INIT,
    OP_DIV_N_END
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INFL,
    ST_READ,
    ST_DRAIN,
    ST_DIVP,
    ST_PEND,
    ST_SHIFT,
    ST_SQ,
    ST_CHK,
    ST_SQRT,
    ST_DIVNI,
    ST_DIVN,
    ST_NEND,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t        op;
    logic       out_load;  // copy results into the output register
    logic [1:0] k;         // influence
    logic [3:0] e;         // matrix element
    logic [1:0] c;         // component
  } cmd_t;

  typedef struct packed {
    logic infl_ok;
    logic wsum_zero;
    logic shift_more;
    logic degenerate;
  } sts_t;

endpackage

@@ rtl/core/linear_blend_vertex_skinning_top.sv @@
// Top level of the four-influence linear blend skinning block.
// Load beat: writes at most one matrix word, no result; skin beats run one at a time.
// Skin beat: walks the influences; unless passed through, divides the position, shifts
//   the normal down while too large and, if not degenerate, runs square root and divide.
// Throughput: next beat is taken the cycle after the result loads; a stalled result holds it.
// Reset (rst_n, sync, active low) clears control state and joint_count; matrix RAM is kept.
`timescale 1ns / 1ps
module linear_blend_vertex_skinning_top import lbvs_pkg::*; #(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF,
  parameter int INFLUENCES = INFLUENCES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration: joint_count
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_joint_count,
  // input beats
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_nrm_x,
  input  logic signed [15:0] in_nrm_y,
  input  logic signed [15:0] in_nrm_z,
  input  logic [27:0]        in_joint_ids,
  input  logic [63:0]        in_blend_weights,
  input  logic [5:0]         in_matrix_joint,
  input  logic [3:0]         in_matrix_element,
  input  logic signed [31:0] in_matrix_value,
  // result beats
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_skin_x,
  output logic signed [31:0] out_skin_y,
  output logic signed [31:0] out_skin_z,
  output logic signed [15:0] out_skin_nx,
  output logic signed [15:0] out_skin_ny,
  output logic signed [15:0] out_skin_nz,
  output logic               out_passed_through
);

  localparam int DEPTH = MAX_JOINTS * ELEMS;
  localparam int AW    = $clog2(DEPTH);

  cmd_t          cmd;
  sts_t          sts;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  // register writes are to be issued only while idle; the block does not enforce this; always ready
  assign cfg_ready = 1'b1;

  lbvs_ctrl #(.INFLUENCES(INFLUENCES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // matrix store: word e of joint j at j*12+e
  lbvs_ram #(.WIDTH(32), .DEPTH(DEPTH), .AW(AW)) u_mat (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lbvs_dpath #(.MAX_JOINTS(MAX_JOINTS), .AW(AW)) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_joint_count    (cfg_joint_count),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_nrm_x           (in_nrm_x),
    .in_nrm_y           (in_nrm_y),
    .in_nrm_z           (in_nrm_z),
    .in_joint_ids       (in_joint_ids),
    .in_blend_weights   (in_blend_weights),
    .in_matrix_joint    (in_matrix_joint),
    .in_matrix_element  (in_matrix_element),
    .in_matrix_value    (in_matrix_value),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_skin_x         (out_skin_x),
    .out_skin_y         (out_skin_y),
    .out_skin_z         (out_skin_z),
    .out_skin_nx        (out_skin_nx),
    .out_skin_ny        (out_skin_ny),
    .out_skin_nz        (out_skin_nz),
    .out_passed_through (out_passed_through)
  );

endmodule

@@ rtl/core/lbvs_ram.sv @@
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module lbvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/lbvs_ctrl.sv @@
// Sequencer for load, influence accumulation, divide and normalize.
`timescale 1ns / 1ps
module lbvs_ctrl import lbvs_pkg::*; #(
  parameter int INFLUENCES = INFLUENCES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam int NINF = (INFLUENCES < FIELD_INFL) ? INFLUENCES : FIELD_INFL;

  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [2:0]  kcnt_r, kcnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      kcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      kcnt_r      <= kcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kcnt_nxt      = kcnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    cmd.op        = OP_NONE;
    cmd.out_load  = 1'b0;
    cmd.k         = kcnt_r[1:0];
    cmd.e         = cnt_r[3:0];
    cmd.c         = cnt_r[1:0];
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          if (in_kind) begin
            cmd.op    = OP_LOAD_ITEM;
            kcnt_nxt  = '0;
            state_nxt = ST_INFL;
          end else begin
            cmd.op = OP_WRITE;
          end
        end
      end
      ST_INFL: begin
        if (kcnt_r == 3'(NINF)) begin
          cnt_nxt = '0;
          if (sts.wsum_zero) begin
            cmd.op    = OP_PASS;
            state_nxt = ST_FINISH;
          end else begin
            cmd.op    = OP_DIV_P_INIT;
            state_nxt = ST_DIVP;
          end
        end else if (sts.infl_ok) begin
          cmd.op    = OP_WSUM;
          cnt_nxt   = '0;
          state_nxt = ST_READ;
        end else begin
          kcnt_nxt = kcnt_r + 3'd1;
        end
      end
      ST_READ: begin
        cmd.op = OP_READ;
        if (cnt_r == 6'd11) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_DRAIN: begin
        if (cnt_r == 6'd4) begin
          cnt_nxt   = '0;
          kcnt_nxt  = kcnt_r + 3'd1;
          state_nxt = ST_INFL;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_DIVP: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == 6'd63) begin
          cnt_nxt   = '0;
          state_nxt = ST_PEND;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_PEND: begin
        cmd.op    = OP_DIV_P_END;
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (sts.shift_more) begin
          cmd.op = OP_SHIFT;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.op = OP_SQ;
        if (cnt_r == 6'd2) begin
          cnt_nxt   = '0;
          state_nxt = ST_CHK;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_CHK: begin
        if (sts.degenerate) begin
          cmd.op    = OP_NRM_BIND;
          state_nxt = ST_FINISH;
        end else begin
          cmd.op    = OP_SQRT_INIT;
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (cnt_r == 6'd31) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIVNI;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_DIVNI: begin
        cmd.op    = OP_DIV_N_INIT;
        cnt_nxt   = '0;
        state_nxt = ST_DIVN;
      end
      ST_DIVN: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == 6'd63) begin
          cnt_nxt   = '0;
          state_nxt = ST_NEND;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_NEND: begin
        cmd.op    = OP_DIV_N_END;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // never overwrite a result beat that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  // a skin beat always starts the influence walk
  a_skin_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_kind) |=> (state_r == ST_INFL && kcnt_r == 3'd0))
    else $error("skin beat did not start influence walk");

  // matrix reads only for an existing influence
  a_read_k: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (kcnt_r < 3'(NINF)))
    else $error("read beyond influence count");

  // pipeline drain is bounded
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (cnt_r <= 6'd4))
    else $error("drain counter overran");

endmodule

@@ rtl/core/lbvs_dpath.sv @@
// Datapath: matrix address, MAC pipeline, dividers, norm and square root.
`timescale 1ns / 1ps
module lbvs_dpath import lbvs_pkg::*; #(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF,
  parameter int AW         = $clog2(MAX_JOINTS * ELEMS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_joint_count,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_nrm_x,
  input  logic signed [15:0] in_nrm_y,
  input  logic signed [15:0] in_nrm_z,
  input  logic [27:0]        in_joint_ids,
  input  logic [63:0]        in_blend_weights,
  input  logic [5:0]         in_matrix_joint,
  input  logic [3:0]         in_matrix_element,
  input  logic signed [31:0] in_matrix_value,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [31:0]        ram_wdata,
  output logic [AW-1:0]      ram_raddr,
  input  logic [31:0]        ram_rdata,
  output logic signed [31:0] out_skin_x,
  output logic signed [31:0] out_skin_y,
  output logic signed [31:0] out_skin_z,
  output logic signed [15:0] out_skin_nx,
  output logic signed [15:0] out_skin_ny,
  output logic signed [15:0] out_skin_nz,
  output logic               out_passed_through
);

  localparam logic [8:0] MAXJ = 9'(MAX_JOINTS);

  logic [6:0]         jc_r;
  logic signed [31:0] p_r [3];
  logic signed [15:0] n_r [3];
  logic [27:0]        ids_r;
  logic [63:0]        bw_r;
  logic [17:0]        wsum_r;

  // MAC pipeline
  logic               t1_v_r, t2_v_r, t3_v_r, t4_v_r;
  logic [3:0]         t1_e_r, t2_e_r;
  logic [1:0]         t3_r_r, t4_r_r;
  logic signed [63:0] pp_r, pp_nxt;
  logic signed [47:0] np_r, np_nxt;
  logic signed [63:0] ps_acc_r, psum, rnd;
  logic signed [49:0] ns_acc_r, nsum;
  logic signed [43:0] ps_row_r, ps_row_nxt, ns_row_r, ns_row_nxt;
  logic signed [60:0] wp_r, wn_r;
  logic signed [63:0] pacc_r [3];
  logic signed [63:0] nacc_r [3];

  // post processing
  logic [63:0] num_r [3];
  logic [31:0] rem_r [3];
  logic [31:0] dvs_r;
  logic        neg_p_r [3];
  logic        neg_n_r [3];
  logic [61:0] red_r [3];
  logic        shifted_r;
  logic [63:0] s2_r;
  logic [63:0] sv_r, sr_r, sb_r;

  logic signed [31:0] res_p_r [3];
  logic signed [15:0] res_n_r [3];
  logic               pass_r;

  logic signed [31:0] m_s, psel;
  logic signed [15:0] nsel;
  logic [15:0]        wk;
  logic [6:0]         jk;
  logic [11:0]        rlin, wlin;
  logic [30:0]        asel;
  logic [63:0]        sqt;

  function automatic logic [31:0] sat32(input logic [63:0] q, input logic neg);
    if (neg) begin
      sat32 = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    end else begin
      sat32 = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
  endfunction

  function automatic logic [15:0] sat16(input logic [63:0] q, input logic neg);
    if (neg) begin
      sat16 = (q > 64'h8000) ? 16'h8000 : 16'(-q);
    end else begin
      sat16 = (q > 64'h7FFF) ? 16'h7FFF : q[15:0];
    end
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  // influence select and matrix addressing
  assign wk   = bw_r[16*cmd.k +: 16];
  assign jk   = ids_r[7*cmd.k +: 7];
  assign rlin = 12'({2'b0, jk} * 9'd12) + 12'(cmd.e);
  assign wlin = 12'({3'b0, in_matrix_joint} * 9'd12) + 12'(in_matrix_element);

  assign ram_raddr = AW'(rlin);
  assign ram_waddr = AW'(wlin);
  assign ram_wdata = in_matrix_value;
  assign ram_we    = (cmd.op == OP_WRITE) && ({3'b0, in_matrix_joint} < MAXJ) &&
                     (in_matrix_element < 4'(ELEMS));

  assign sts.infl_ok    = (wk != 16'd0) && ({2'b0, jk} < {2'b0, jc_r}) &&
                          ({2'b0, jk} < MAXJ);
  assign sts.wsum_zero  = (wsum_r == 18'd0);
  assign sts.shift_more = (red_r[0] > RED_LIM) || (red_r[1] > RED_LIM) ||
                          (red_r[2] > RED_LIM);
  assign sts.degenerate = !shifted_r && (s2_r <= NRM_EPS_SQ);

  // stage 2: products
  assign m_s = ram_rdata;
  always_comb begin
    case (t1_e_r[1:0])
      2'd0:    begin psel = p_r[0]; nsel = n_r[0]; end
      2'd1:    begin psel = p_r[1]; nsel = n_r[1]; end
      default: begin psel = p_r[2]; nsel = n_r[2]; end
    endcase
    if (t1_e_r[1:0] == 2'd3) begin
      pp_nxt = {{16{m_s[31]}}, m_s, 16'd0};  // translation, scaled to Q.32
      np_nxt = '0;
    end else begin
      pp_nxt = m_s * psel;
      np_nxt = m_s * nsel;
    end
  end

  // stage 3: row sum, round and clamp
  always_comb begin
    psum = ps_acc_r + (pp_r >>> 2);
    nsum = ns_acc_r + 50'(np_r);
    rnd  = (psum + 64'sd8192) >>> 14;
    if (rnd > 64'sd8796093022207) begin
      ps_row_nxt = 44'h7FF_FFFF_FFFF;
    end else if (rnd < -64'sd8796093022208) begin
      ps_row_nxt = 44'h800_0000_0000;
    end else begin
      ps_row_nxt = rnd[43:0];
    end
    if (nsum > 50'sd8796093022207) begin
      ns_row_nxt = 44'h7FF_FFFF_FFFF;
    end else if (nsum < -50'sd8796093022208) begin
      ns_row_nxt = 44'h800_0000_0000;
    end else begin
      ns_row_nxt = nsum[43:0];
    end
  end

  always_comb begin
    case (cmd.c)
      2'd0:    asel = red_r[0][30:0];
      2'd1:    asel = red_r[1][30:0];
      default: asel = red_r[2][30:0];
    endcase
    sqt = sr_r + sb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jc_r   <= '0;
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
      t4_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        jc_r <= cfg_joint_count;
      end
      t1_v_r <= (cmd.op == OP_READ);
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r && (t2_e_r[1:0] == 2'd3);
      t4_v_r <= t3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_e_r <= cmd.e;
    t2_e_r <= t1_e_r;
    pp_r   <= pp_nxt;
    np_r   <= np_nxt;
    t3_r_r <= t2_e_r[3:2];
    t4_r_r <= t3_r_r;
    wp_r   <= ps_row_r * $signed({1'b0, wk});
    wn_r   <= ns_row_r * $signed({1'b0, wk});

    if (t2_v_r) begin
      if (t2_e_r[1:0] == 2'd3) begin
        ps_row_r <= ps_row_nxt;
        ns_row_r <= ns_row_nxt;
        ps_acc_r <= '0;
        ns_acc_r <= '0;
      end else begin
        ps_acc_r <= psum;
        ns_acc_r <= nsum;
      end
    end

    for (int c = 0; c < 3; c++) begin
      if (t4_v_r && t4_r_r == 2'(c)) begin
        pacc_r[c] <= pacc_r[c] + 64'(wp_r);
        nacc_r[c] <= nacc_r[c] + 64'(wn_r);
      end
    end

    case (cmd.op)
      OP_LOAD_ITEM: begin
        p_r[0] <= in_pos_x;
        p_r[1] <= in_pos_y;
        p_r[2] <= in_pos_z;
        n_r[0] <= in_nrm_x;
        n_r[1] <= in_nrm_y;
        n_r[2] <= in_nrm_z;
        ids_r  <= in_joint_ids;
        bw_r   <= in_blend_weights;
        wsum_r <= '0;
        ps_acc_r <= '0;
        ns_acc_r <= '0;
        for (int c = 0; c < 3; c++) begin
          pacc_r[c] <= '0;
          nacc_r[c] <= '0;
        end
      end
      OP_WSUM: wsum_r <= wsum_r + 18'(wk);
      OP_PASS: begin
        for (int c = 0; c < 3; c++) begin
          res_p_r[c] <= p_r[c];
          res_n_r[c] <= n_r[c];
        end
        pass_r <= 1'b1;
      end
      OP_DIV_P_INIT: begin
        for (int c = 0; c < 3; c++) begin
          num_r[c]   <= mag64(pacc_r[c]) + 64'(wsum_r[17:1]);
          rem_r[c]   <= '0;
          neg_p_r[c] <= pacc_r[c][63];
          neg_n_r[c] <= nacc_r[c][63];
          red_r[c]   <= 62'(mag64(nacc_r[c]));
        end
        dvs_r     <= 32'(wsum_r);
        shifted_r <= 1'b0;
        s2_r      <= '0;
      end
      OP_DIV_STEP: begin
        for (int c = 0; c < 3; c++) begin
          if ({rem_r[c], num_r[c][63]} >= {1'b0, dvs_r}) begin
            rem_r[c] <= 32'({rem_r[c], num_r[c][63]} - {1'b0, dvs_r});
            num_r[c] <= {num_r[c][62:0], 1'b1};
          end else begin
            rem_r[c] <= {rem_r[c][30:0], num_r[c][63]};
            num_r[c] <= {num_r[c][62:0], 1'b0};
          end
        end
      end
      OP_DIV_P_END: begin
        for (int c = 0; c < 3; c++) begin
          res_p_r[c] <= sat32(num_r[c], neg_p_r[c]);
        end
        pass_r <= 1'b0;
      end
      OP_SHIFT: begin
        for (int c = 0; c < 3; c++) begin
          red_r[c] <= red_r[c] >> 1;
        end
        shifted_r <= 1'b1;
      end
      OP_SQ: s2_r <= s2_r + 64'(asel * asel);
      OP_NRM_BIND: begin
        for (int c = 0; c < 3; c++) begin
          res_n_r[c] <= n_r[c];
        end
      end
      OP_SQRT_INIT: begin
        sv_r <= s2_r;
        sr_r <= '0;
        sb_r <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sv_r >= sqt) begin
          sv_r <= sv_r - sqt;
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r <= sb_r >> 2;
      end
      OP_DIV_N_INIT: begin
        for (int c = 0; c < 3; c++) begin
          num_r[c] <= 64'({red_r[c][30:0], 14'd0}) + 64'(sr_r[31:1]);
          rem_r[c] <= '0;
        end
        dvs_r <= sr_r[31:0];
      end
      OP_DIV_N_END: begin
        for (int c = 0; c < 3; c++) begin
          res_n_r[c] <= sat16(num_r[c], neg_n_r[c]);
        end
      end
      default: ;
    endcase

    if (cmd.out_load) begin
      out_skin_x         <= res_p_r[0];
      out_skin_y         <= res_p_r[1];
      out_skin_z         <= res_p_r[2];
      out_skin_nx        <= res_n_r[0];
      out_skin_ny        <= res_n_r[1];
      out_skin_nz        <= res_n_r[2];
      out_passed_through <= pass_r;
    end
  end

endmodule

@@ tb/sv/linear_blend_vertex_skinning_top_tb.sv @@
// Self-checking testbench for the four-influence linear blend skinning block.
`timescale 1ns / 1ps
module linear_blend_vertex_skinning_top_tb;
  import lbvs_pkg::*;

  localparam int NJ = MAX_JOINTS_DEF;
  localparam int LOADED_J = 24;   // joints filled with random matrices
  localparam int PH_VERTS = 25;   // vertices per random phase
  localparam longint SAT44 = 64'sd1 << 43;

  // One input beat as the driver presents it.
  typedef struct {
    logic              kind;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [27:0]       ids;
    logic [63:0]       wts;
    logic [5:0]        mj;
    logic [3:0]        me;
    logic signed [31:0] mv;
  } vtx_beat_t;

  // One skinned vertex.
  typedef struct {
    logic signed [31:0] x, y, z;
    logic signed [15:0] nx, ny, nz;
    logic              pass;
  } skin_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_joint_count = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_taken = 1'b0;
  logic in_kind = 1'b0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_nrm_x = '0, in_nrm_y = '0, in_nrm_z = '0;
  logic [27:0] in_joint_ids = '0;
  logic [63:0] in_blend_weights = '0;
  logic [5:0] in_matrix_joint = '0;
  logic [3:0] in_matrix_element = '0;
  logic signed [31:0] in_matrix_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_skin_x, out_skin_y, out_skin_z;
  logic signed [15:0] out_skin_nx, out_skin_ny, out_skin_nz;
  logic out_passed_through;

  linear_blend_vertex_skinning_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_joint_count(cfg_joint_count),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_nrm_x(in_nrm_x), .in_nrm_y(in_nrm_y), .in_nrm_z(in_nrm_z),
    .in_joint_ids(in_joint_ids), .in_blend_weights(in_blend_weights),
    .in_matrix_joint(in_matrix_joint), .in_matrix_element(in_matrix_element),
    .in_matrix_value(in_matrix_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_skin_x(out_skin_x), .out_skin_y(out_skin_y), .out_skin_z(out_skin_z),
    .out_skin_nx(out_skin_nx), .out_skin_ny(out_skin_ny), .out_skin_nz(out_skin_nz),
    .out_passed_through(out_passed_through)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the joint matrices and joint_count.
  logic [31:0] joint_mat [NJ*ELEMS];
  logic [6:0]  joint_cnt_m;

  vtx_beat_t pending_beats[$];
  skin_res_t expected_skins[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Predictor arithmetic
  // ---------------------------------------------------------------------------
  function automatic longint flr_shr(longint v, int s);
    return v >>> s;  // arithmetic shift floors
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned magl(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint rnd_div(longint a, longint unsigned d);
    longint unsigned q;
    q = (magl(a) + d / 2) / d;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint mat_elem(int j, int e);
    return longint'($signed(joint_mat[j*ELEMS + e]));
  endfunction

  // Skins one vertex beat against the shadow matrices.
  function automatic skin_res_t skin_vertex(vtx_beat_t b);
    skin_res_t res;
    longint p[3], n[3], pacc[3], nacc[3], red[3];
    longint ps, ns, m;
    longint unsigned wsum, w, j, nj, mx, s2, a, sq;
    int sh;
    p[0] = longint'(b.px); p[1] = longint'(b.py); p[2] = longint'(b.pz);
    n[0] = longint'(b.nx); n[1] = longint'(b.ny); n[2] = longint'(b.nz);
    pacc = '{0, 0, 0};
    nacc = '{0, 0, 0};
    wsum = 0;
    nj = joint_cnt_m < NJ ? joint_cnt_m : NJ;
    for (int k = 0; k < FIELD_INFL; k++) begin
      w = (b.wts >> (16*k)) & 64'hFFFF;
      j = (b.ids >> (7*k)) & 64'h7F;
      if (w == 0 || j >= nj) continue;
      wsum += w;
      for (int r = 0; r < 3; r++) begin
        ps = 0;
        ns = 0;
        for (int c = 0; c < 3; c++) begin
          m = mat_elem(int'(j), r*4 + c);
          ps += flr_shr(m * p[c], 2);
          ns += m * n[c];
        end
        ps += mat_elem(int'(j), r*4 + 3) * 16384;
        ps = clampl(flr_shr(ps + 8192, 14), -SAT44, SAT44 - 1);
        ns = clampl(ns, -SAT44, SAT44 - 1);
        pacc[r] += ps * longint'(w);
        nacc[r] += ns * longint'(w);
      end
    end
    res.pass = (wsum == 0);
    if (wsum == 0) begin
      res.x = b.px; res.y = b.py; res.z = b.pz;
      res.nx = b.nx; res.ny = b.ny; res.nz = b.nz;
    end else begin
      res.x = 32'(clampl(rnd_div(pacc[0], wsum), -(64'sd1 << 31), (64'sd1 << 31) - 1));
      res.y = 32'(clampl(rnd_div(pacc[1], wsum), -(64'sd1 << 31), (64'sd1 << 31) - 1));
      res.z = 32'(clampl(rnd_div(pacc[2], wsum), -(64'sd1 << 31), (64'sd1 << 31) - 1));
      mx = 0;
      for (int c = 0; c < 3; c++) if (magl(nacc[c]) > mx) mx = magl(nacc[c]);
      sh = 0;
      while ((mx >> sh) > RED_LIM) sh++;
      s2 = 0;
      for (int c = 0; c < 3; c++) begin
        a = magl(nacc[c]) >> sh;
        red[c] = nacc[c] < 0 ? -longint'(a) : longint'(a);
        s2 += a * a;
      end
      if (sh == 0 && s2 <= NRM_EPS_SQ) begin
        // degenerate skinned normal: bind normal comes back
        res.nx = b.nx; res.ny = b.ny; res.nz = b.nz;
      end else begin
        sq = isqrt(s2);
        res.nx = 16'(clampl(rnd_div(red[0] * 16384, sq), -32768, 32767));
        res.ny = 16'(clampl(rnd_div(red[1] * 16384, sq), -32768, 32767));
        res.nz = 16'(clampl(rnd_div(red[2] * 16384, sq), -32768, 32767));
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one beat at a time from pending_beats, random idle cycles.
  // ---------------------------------------------------------------------------
  // acceptance seen at the rising edge, used by the driver on the falling edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        // beat was taken at the last rising edge; update the matrix shadow
        if (in_kind == 1'b0) begin
          if (in_matrix_element < ELEMS) begin
            joint_mat[in_matrix_joint*ELEMS + in_matrix_element] = in_matrix_value;
          end
        end
      end
      if (!in_valid || in_taken) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          vtx_beat_t b;
          b = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_kind <= b.kind;
          in_pos_x <= b.px; in_pos_y <= b.py; in_pos_z <= b.pz;
          in_nrm_x <= b.nx; in_nrm_y <= b.ny; in_nrm_z <= b.nz;
          in_joint_ids <= b.ids;
          in_blend_weights <= b.wts;
          in_matrix_joint <= b.mj;
          in_matrix_element <= b.me;
          in_matrix_value <= b.mv;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Expectation is formed at the accepting edge, before any later load lands.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall && in_kind == 1'b1) begin
      vtx_beat_t b;
      b.kind = 1'b1;
      b.px = in_pos_x; b.py = in_pos_y; b.pz = in_pos_z;
      b.nx = in_nrm_x; b.ny = in_nrm_y; b.nz = in_nrm_z;
      b.ids = in_joint_ids; b.wts = in_blend_weights;
      b.mj = '0; b.me = '0; b.mv = '0;
      expected_skins.insert(expected_skins.size(), skin_vertex(b));
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result beat with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      skin_res_t e;
      if (expected_skins.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected: %0d %0d %0d", $time,
                 out_skin_x, out_skin_y, out_skin_z);
      end else begin
        e = expected_skins.pop_front();
        if (out_skin_x !== e.x || out_skin_y !== e.y || out_skin_z !== e.z ||
            out_skin_nx !== e.nx || out_skin_ny !== e.ny || out_skin_nz !== e.nz ||
            out_passed_through !== e.pass) begin
          errors++;
          $display("%0t: mismatch expected pos %0d %0d %0d nrm %0d %0d %0d pt %0b",
                   $time, e.x, e.y, e.z, e.nx, e.ny, e.nz, e.pass);
          $display("%0t:          actual   pos %0d %0d %0d nrm %0d %0d %0d pt %0b",
                   $time, out_skin_x, out_skin_y, out_skin_z, out_skin_nx,
                   out_skin_ny, out_skin_nz, out_passed_through);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic vtx_beat_t load_beat(int j, int e, logic [31:0] v);
    vtx_beat_t b;
    b = '{default: '0};
    b.kind = 1'b0;
    b.mj = 6'(j); b.me = 4'(e); b.mv = v;
    // junk in the unused vertex fields
    b.px = $urandom; b.ids = 28'($urandom);
    return b;
  endfunction

  function automatic vtx_beat_t skin_beat(logic [31:0] px, logic [31:0] py,
                                          logic [31:0] pz, logic [15:0] nx,
                                          logic [15:0] ny, logic [15:0] nz,
                                          logic [27:0] ids, logic [63:0] wts);
    vtx_beat_t b;
    b.kind = 1'b1;
    b.px = px; b.py = py; b.pz = pz;
    b.nx = nx; b.ny = ny; b.nz = nz;
    b.ids = ids; b.wts = wts;
    b.mj = 6'($urandom); b.me = 4'($urandom); b.mv = $urandom;
    return b;
  endfunction

  // Random matrix element: mostly small rotations/scales, sometimes full range.
  function automatic logic [31:0] rand_elem(int e);
    case ($urandom_range(9))
      0: return $urandom;
      1: return (e % 4 == 3) ? 32'h7FFFFFFF : 32'h80000000;
      default: return (e % 4 == 3) ? 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23))
                                   : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  // Index that hits only fully-written joints or slots past the joint count.
  function automatic logic [6:0] rand_joint(int loaded);
    int nj;
    nj = (int'(joint_cnt_m) < NJ) ? int'(joint_cnt_m) : NJ;
    if ($urandom_range(9) == 0)
      return 7'($urandom_range((nj > loaded) ? nj : loaded, 127));
    return 7'($urandom_range(0, loaded - 1));
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(7))
      0: return 16'h0;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_valid || expected_skins.size() > 0)
      @(posedge clk);
    // no-result loads might still be in flight; allow the block's latency
    repeat (300) @(posedge clk);
  endtask

  task automatic write_joint_count(logic [6:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_joint_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    joint_cnt_m = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random_vertex(int loaded);
    logic [27:0] ids;
    logic [63:0] wts;
    for (int k = 0; k < 4; k++) begin
      ids[7*k +: 7] = rand_joint(loaded);
      wts[16*k +: 16] = rand_weight();
    end
    pending_beats.insert(pending_beats.size(),
                         skin_beat(rand_pos(), rand_pos(), rand_pos(), 16'($urandom),
                                   16'($urandom), 16'($urandom), ids, wts));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int loaded;
    foreach (joint_mat[i]) begin
      joint_mat[i] = '0;
    end
    joint_cnt_m = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: joint_count at reset is 0, so every vertex passes through.
    pending_beats.insert(pending_beats.size(),
                         skin_beat(32'h7FFFFFFF, 32'h80000000, 32'h0, 16'h7FFF,
                                   16'h8000, 16'h0, 28'h0, 64'h0001_8000_FFFF_0001));
    wait_drained();

    // Load joints 0..3: identity, translate, scaled, all-zero (degenerate normal).
    for (int e = 0; e < ELEMS; e++) begin
      pending_beats.insert(pending_beats.size(),
                           load_beat(0, e, (e == 0 || e == 5 || e == 10) ? 32'h10000 : 0));
      pending_beats.insert(pending_beats.size(),
                           load_beat(1, e, (e == 0 || e == 5 || e == 10) ? 32'h10000 :
                                           (e % 4 == 3) ? 32'h00030000 : 0));
      pending_beats.insert(pending_beats.size(),
                           load_beat(2, e, (e % 4 == 3) ? 32'h80000000 : 32'h7FFFFFFF));
      pending_beats.insert(pending_beats.size(), load_beat(3, e, 32'h0));
    end
    // out-of-range element is ignored
    pending_beats.insert(pending_beats.size(), load_beat(0, 12, 32'hDEADBEEF));
    pending_beats.insert(pending_beats.size(), load_beat(63, 15, 32'h12345678));
    wait_drained();
    write_joint_count(7'd4);
    loaded = 4;

    // identity, full weight
    pending_beats.insert(pending_beats.size(),
                         skin_beat(32'h00010000, 32'hFFFF0000, 32'h00028000,
                                   16'h4000, 16'h0, 16'h0, 28'h0, 64'h8000));
    // two influences, tie blending
    pending_beats.insert(pending_beats.size(),
                         skin_beat(32'h1, 32'h3, 32'hFFFFFFFF, 16'h0, 16'h4000, 16'h0,
                                   {7'd0, 7'd0, 7'd1, 7'd0}, 64'h0000_0000_0001_0001));
    // saturating matrix, extreme position, all weights maxed
    pending_beats.insert(pending_beats.size(),
                         skin_beat(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                   16'h7FFF, 16'h8000, 16'h7FFF,
                                   {7'd2, 7'd2, 7'd2, 7'd2}, 64'hFFFF_FFFF_FFFF_FFFF));
    // degenerate normal from the zero matrix
    pending_beats.insert(pending_beats.size(),
                         skin_beat(32'h00050000, 32'h0, 32'h0, 16'h1234, 16'h8000,
                                   16'h7FFF, {7'd3, 7'd3, 7'd3, 7'd3}, 64'h8000));
    // joints beyond the count and zero weights: pass-through
    pending_beats.insert(pending_beats.size(),
                         skin_beat(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                                   {7'd127, 7'd64, 7'd4, 7'd0}, 64'h0001_FFFF_8000_0000));
    // zero bind normal through identity is degenerate too
    pending_beats.insert(pending_beats.size(),
                         skin_beat(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                                   {7'd1, 7'd0, 7'd1, 7'd0}, 64'h1111_2222_3333_4444));
    wait_drained();

    // Fill the low joint slots with random matrices, then run random phases.
    for (int j = 0; j < LOADED_J; j++)
      for (int e = 0; e < ELEMS; e++)
        pending_beats.insert(pending_beats.size(), load_beat(j, e, rand_elem(e)));
    wait_drained();

    // Phases sweep joint_count and idling patterns, counts include extremes.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_joint_count(7'd64);  send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin write_joint_count(7'd127); send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin write_joint_count(7'd1);   send_idle_pct = 0;  recv_stall_pct = 59; end
        3: begin write_joint_count(7'd0);   send_idle_pct = 21; recv_stall_pct = 21; end
        4: begin write_joint_count(7'd33);  send_idle_pct = 59; recv_stall_pct = 59; end
        default: begin write_joint_count(7'd64); send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      loaded = LOADED_J;
      for (int i = 0; i < PH_VERTS; i++) begin
        // occasional matrix rewrite in flight with vertices
        if ($urandom_range(4) == 0)
          pending_beats.insert(pending_beats.size(),
                               load_beat($urandom_range(NJ - 1), $urandom_range(15),
                                         rand_elem($urandom_range(11))));
        queue_random_vertex(loaded);
        // sender holds off until every expected result has come
        if (i == PH_VERTS / 2) begin
          while (pending_beats.size() > 0 || in_valid || expected_skins.size() > 0)
            @(posedge clk);
        end
      end
      wait_drained();
    end

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Slowest run: ~500 beats and ~160 vertices, far below this.
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
